/* hw/rtl/ipra_pkg.sv */
// Package for the I/O port range allocator: payload types, status and command codes,
// sequencer states and the shared constants. No dependencies.
package ipra_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam logic [16:0] SEARCH_BASE = 17'h00400;
  localparam logic [16:0] PORT_LIMIT  = 17'h10000;

  typedef enum logic [2:0] {
    CMD_CLAIM_FIXED = 3'd0,
    CMD_CLAIM_ANY   = 3'd1,
    CMD_RESERVE_ANY = 3'd2,
    CMD_FREE        = 3'd3,
    CMD_QUERY       = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_CLAIMED  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_FREED    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_INSERT,
    S_INSERT2,
    S_UNLINK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] port;
    logic [16:0] size;
    logic [16:0] align;
    logic [16:0] end_port;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_port;
    logic        unused;
  } rsp_t;

  // Control between sequencer and the rounding unit.
  typedef struct packed {
    logic        start;
    logic [16:0] value;
    logic [16:0] align;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [17:0] rounded;
  } div_rsp_t;

endpackage

/* hw/rtl/io_port_range_allocator.sv */
// I/O port range allocator: one item at a time, walking a linked table with a read state
// and an evaluate state per entry visited; an aligned search step waits in the DIV state
// for the round-up unit. Not ready while a command is in work or its result waits, nor
// while the sequencer returns from DONE to IDLE after the result transfer. Reset (async,
// active low) empties the used list and chains all links; no clearing pass.
module io_port_range_allocator #(
  parameter int unsigned ENTRIES = ipra_pkg::ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ipra_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ipra_pkg::rsp_t  out_data_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [8:0] STEP_MAX = 9'(ENTRIES);

  // Entry storage (memories) and links in flip-flops.
  logic [15:0]   start_mem [ENTRIES];
  logic [16:0]   end_mem   [ENTRIES];
  logic          res_mem   [ENTRIES];
  logic [LW-1:0] link_q    [ENTRIES];
  logic [LW-1:0] used_head_q, free_head_q;

  ipra_pkg::state_e state_q, state_d;
  ipra_pkg::req_t   req_q;
  ipra_pkg::rsp_t   rsp_q, rsp_d;
  logic             out_valid_q;

  logic [LW-1:0] prev_q, prev_d, cur_q, cur_d;
  logic [8:0]    steps_q, steps_d;
  logic [17:0]   cand_q, cand_d;
  logic [15:0]   rd_start_q;
  logic [16:0]   rd_end_q;
  logic          rd_res_q;

  // Write-side controls driven by the output block.
  logic          we_entry, we_res_clr, set_link_en, cur_link_en, free_head_en;
  logic [LW-1:0] set_link_prev, set_link_val, cur_link_val, free_head_val;
  logic [IW-1:0] wr_idx;
  logic [15:0]   wr_start;
  logic [16:0]   wr_end;
  logic          wr_res;

  ipra_pkg::div_req_t div_req;
  ipra_pkg::div_rsp_t div_rsp;

  logic [17:0]   lim;
  logic [LW-1:0] cur_next;
  logic [LW-1:0] prev_link;

  ipra_round_up u_round (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign lim = {2'b0, req_q.port} + {1'b0, req_q.size};
  assign cur_next = link_q[cur_q[IW-1:0]];
  assign prev_link = (prev_q == NIL) ? used_head_q : link_q[prev_q[IW-1:0]];

  assign in_ready_o  = (state_q == ipra_pkg::S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // Next-state and datapath control.
  always_comb begin
    state_d = state_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    steps_d = steps_q;
    cand_d  = cand_q;
    rsp_d   = rsp_q;
    case (state_q)
      ipra_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = ipra_pkg::S_READ;
          prev_d  = NIL;
          cur_d   = used_head_q;
          steps_d = '0;
          cand_d  = {1'b0, ipra_pkg::SEARCH_BASE};
          rsp_d   = '{status: ipra_pkg::ST_REFUSED, granted_port: '0, unused: 1'b0};
          case (in_data_i.cmd)
            ipra_pkg::CMD_CLAIM_FIXED: begin
              if ({2'b0, in_data_i.port} + {1'b0, in_data_i.size} >
                  {1'b0, ipra_pkg::PORT_LIMIT}) begin
                state_d = ipra_pkg::S_DONE;
              end
            end
            ipra_pkg::CMD_CLAIM_ANY, ipra_pkg::CMD_RESERVE_ANY: ;
            ipra_pkg::CMD_FREE: rsp_d.status = ipra_pkg::ST_NOTFOUND;
            ipra_pkg::CMD_QUERY: begin
              rsp_d.status = ipra_pkg::ST_RECORDED;
              rsp_d.unused = 1'b1;
            end
            default: state_d = ipra_pkg::S_DONE;
          endcase
        end
      end
      ipra_pkg::S_READ: begin
        if (cur_q == NIL || steps_q == STEP_MAX) begin
          // End of walk.
          case (req_q.cmd)
            ipra_pkg::CMD_CLAIM_FIXED: state_d = ipra_pkg::S_INSERT;
            default: state_d = ipra_pkg::S_DONE;
          endcase
        end else begin
          state_d = ipra_pkg::S_EVAL;
          steps_d = steps_q + 9'd1;
        end
      end
      ipra_pkg::S_EVAL: begin
        state_d = ipra_pkg::S_READ;
        case (req_q.cmd)
          ipra_pkg::CMD_CLAIM_FIXED: begin
            if (rd_end_q <= {1'b0, req_q.port}) begin
              prev_d = cur_q;
              cur_d  = cur_next;
            end else if (rd_res_q && rd_start_q == req_q.port && {1'b0, rd_end_q} == lim) begin
              rsp_d.status       = ipra_pkg::ST_CLAIMED;
              rsp_d.granted_port = req_q.port;
              state_d            = ipra_pkg::S_DONE;
            end else if ({2'b0, rd_start_q} < lim) begin
              state_d = ipra_pkg::S_DONE;
            end else begin
              state_d = ipra_pkg::S_INSERT;
            end
          end
          ipra_pkg::CMD_CLAIM_ANY, ipra_pkg::CMD_RESERVE_ANY: begin
            prev_d = cur_q;
            cur_d  = cur_next;
            if ({1'b0, rd_start_q} >= ipra_pkg::SEARCH_BASE) begin
              if ({2'b0, rd_start_q} > cand_q &&
                  {2'b0, rd_start_q} - cand_q > {1'b0, req_q.size}) begin
                prev_d  = prev_q;
                cur_d   = cur_q;
                state_d = ipra_pkg::S_INSERT;
              end else if (req_q.align != '0) begin
                state_d = ipra_pkg::S_DIV;
              end else begin
                cand_d = {1'b0, rd_end_q};
              end
            end
          end
          ipra_pkg::CMD_FREE: begin
            if (rd_start_q == req_q.port) begin
              rsp_d.status = ipra_pkg::ST_FREED;
              state_d      = ipra_pkg::S_UNLINK;
            end else if (rd_start_q > req_q.port) begin
              state_d = ipra_pkg::S_DONE;
            end else begin
              prev_d = cur_q;
              cur_d  = cur_next;
            end
          end
          default: begin
            if (({1'b0, req_q.port} >= {1'b0, rd_start_q} && {1'b0, req_q.port} < rd_end_q) ||
                (req_q.port <= rd_start_q && req_q.end_port > {1'b0, rd_start_q})) begin
              rsp_d.unused = 1'b0;
              state_d      = ipra_pkg::S_DONE;
            end else begin
              cur_d = cur_next;
            end
          end
        endcase
      end
      ipra_pkg::S_DIV: begin
        if (div_rsp.done) begin
          cand_d  = div_rsp.rounded;
          state_d = ipra_pkg::S_READ;
        end
      end
      ipra_pkg::S_INSERT: begin
        state_d = ipra_pkg::S_DONE;
        rsp_d.granted_port = (req_q.cmd == ipra_pkg::CMD_CLAIM_FIXED) ?
                             req_q.port : cand_q[15:0];
        rsp_d.status = (free_head_q == NIL) ? ipra_pkg::ST_FULL : ipra_pkg::ST_RECORDED;
      end
      ipra_pkg::S_UNLINK: state_d = ipra_pkg::S_DONE;
      ipra_pkg::S_DONE: begin
        if (!out_valid_q) begin
          state_d = ipra_pkg::S_IDLE;
        end
      end
      default: state_d = ipra_pkg::S_IDLE;
    endcase
  end

  // Output block: storage writes and the rounding request.
  always_comb begin
    we_entry      = 1'b0;
    we_res_clr    = 1'b0;
    set_link_en   = 1'b0;
    set_link_prev = prev_q;
    set_link_val  = cur_q;
    cur_link_en   = 1'b0;
    cur_link_val  = cur_q;
    free_head_en  = 1'b0;
    free_head_val = free_head_q;
    wr_idx        = free_head_q[IW-1:0];
    wr_start      = req_q.port;
    wr_end        = lim[16:0];
    wr_res        = 1'b0;
    div_req       = '{start: 1'b0, value: rd_end_q, align: req_q.align};
    case (state_q)
      ipra_pkg::S_EVAL: begin
        if ((req_q.cmd == ipra_pkg::CMD_CLAIM_ANY || req_q.cmd == ipra_pkg::CMD_RESERVE_ANY) &&
            {1'b0, rd_start_q} >= ipra_pkg::SEARCH_BASE && req_q.align != '0 &&
            !({2'b0, rd_start_q} > cand_q &&
              {2'b0, rd_start_q} - cand_q > {1'b0, req_q.size})) begin
          div_req.start = 1'b1;
        end
        if (req_q.cmd == ipra_pkg::CMD_CLAIM_FIXED && rd_end_q > {1'b0, req_q.port} &&
            rd_res_q && rd_start_q == req_q.port && {1'b0, rd_end_q} == lim) begin
          we_res_clr = 1'b1;
        end
      end
      ipra_pkg::S_INSERT: begin
        if (free_head_q != NIL) begin
          we_entry = 1'b1;
          if (req_q.cmd != ipra_pkg::CMD_CLAIM_FIXED) begin
            wr_start = cand_q[15:0];
            wr_end   = cand_q[16:0] + req_q.size;
            wr_res   = (req_q.cmd == ipra_pkg::CMD_RESERVE_ANY);
          end
          free_head_en  = 1'b1;
          free_head_val = link_q[free_head_q[IW-1:0]];
          cur_link_en   = 1'b1;
          cur_link_val  = prev_link;
          set_link_en   = 1'b1;
          set_link_val  = free_head_q;
        end
      end
      ipra_pkg::S_UNLINK: begin
        set_link_en   = 1'b1;
        set_link_val  = cur_next;
        cur_link_en   = 1'b1;
        cur_link_val  = free_head_q;
        free_head_en  = 1'b1;
        free_head_val = cur_q;
      end
      default: ;
    endcase
  end

  // Entry memories: one write port, registered read of the current entry.
  always_ff @(posedge clk_i) begin
    if (we_entry) begin
      start_mem[wr_idx] <= wr_start;
      end_mem[wr_idx]   <= wr_end;
      res_mem[wr_idx]   <= wr_res;
    end else if (we_res_clr) begin
      res_mem[cur_q[IW-1:0]] <= 1'b0;
    end
    rd_start_q <= start_mem[cur_q[IW-1:0]];
    rd_end_q   <= end_mem[cur_q[IW-1:0]];
    rd_res_q   <= res_mem[cur_q[IW-1:0]];
  end

  // Links: in INSERT the new slot takes prev's old link; in UNLINK the freed slot
  // points at the old free head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        link_q[k] <= LW'(k + 1);
      end
      used_head_q <= NIL;
      free_head_q <= '0;
    end else begin
      if (set_link_en) begin
        if (set_link_prev == NIL) begin
          used_head_q <= set_link_val;
        end else begin
          link_q[set_link_prev[IW-1:0]] <= set_link_val;
        end
      end
      if (cur_link_en) begin
        if (state_q == ipra_pkg::S_INSERT) begin
          link_q[free_head_q[IW-1:0]] <= cur_link_val;
        end else begin
          link_q[cur_q[IW-1:0]] <= cur_link_val;
        end
      end
      if (free_head_en) begin
        free_head_q <= free_head_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipra_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= NIL;
      cur_q       <= NIL;
      steps_q     <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      cur_q   <= cur_d;
      steps_q <= steps_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if (state_q != ipra_pkg::S_DONE && state_d == ipra_pkg::S_DONE) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    rsp_q  <= rsp_d;
    cand_q <= cand_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !out_valid_q)
    else $error("ready while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipra_pkg::S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on idle rounding unit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) steps_q <= STEP_MAX)
    else $error("walk exceeded table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_entry |-> free_head_q != NIL))
    else $error("insert with no free slot");

endmodule

/* hw/rtl/ipra_round_up.sv */
// Iterative round-up unit: result = ceil(value / align) * align, restoring division
// one quotient bit per cycle. Depends on ipra_pkg.
module ipra_round_up (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipra_pkg::div_req_t req_i,
  output ipra_pkg::div_rsp_t rsp_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] num_q, num_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [17:0] val_q, val_d;
  logic [17:0] trial;

  assign trial = {rem_q[16:0], num_q[17]};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    val_d  = val_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd18;
      num_d  = {1'b0, req_i.value};
      rem_d  = '0;
      den_d  = req_i.align;
      val_d  = {1'b0, req_i.value};
    end else if (busy_q) begin
      num_d = {num_q[16:0], 1'b0};
      rem_d = trial;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    val_q <= val_d;
  end

  // Remainder of zero keeps the value; otherwise add the distance to the next multiple.
  always_comb begin
    rsp_o.busy    = busy_q;
    rsp_o.done    = done_q;
    rsp_o.rounded = (rem_q == '0) ? val_q : val_q + ({1'b0, den_q} - rem_q);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("round-up done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("round-up did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && den_q != '0) |-> rem_q < {1'b0, den_q})
    else $error("remainder not below divisor");

endmodule

/* sim/tb_top.sv */
// Testbench for io_port_range_allocator: drives commands, predicts each response
// with a behavioral copy of the range table and checks every transfer. Needs ipra_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 32;
  localparam int NULL_IDX = NSLOT;
  localparam int LIMIT_CYCLES = 10000000;

  // Behavioral range table with its expected-response queue.
  class range_table_sb;
    logic [15:0]    rstart [NSLOT];
    logic [16:0]    rend [NSLOT];
    bit             rmark [NSLOT];
    int             nxt [NSLOT];
    int             used_head;
    int             free_head;
    ipra_pkg::rsp_t pending_rsp [$];
    int             errors;

    function new();
      for (int k = 0; k < NSLOT; k++) begin
        nxt[k] = k + 1;
        rstart[k] = '0;
        rend[k] = '0;
        rmark[k] = 0;
      end
      used_head = NULL_IDX;
      free_head = 0;
      errors = 0;
    endfunction

    function int link_of(int prev);
      return (prev >= NSLOT) ? used_head : nxt[prev];
    endfunction

    function void set_link(int prev, int v);
      if (prev >= NSLOT) used_head = v;
      else nxt[prev] = v;
    endfunction

    function bit add_after(int prev, longint s, longint e, bit res);
      int slot;
      slot = free_head;
      if (slot >= NSLOT) return 0;
      free_head = nxt[slot];
      rstart[slot] = s[15:0];
      rend[slot] = e[16:0];
      rmark[slot] = res;
      nxt[slot] = link_of(prev);
      set_link(prev, slot);
      return 1;
    endfunction

    function int count_used();
      int n, c;
      n = 0;
      c = used_head;
      while (c < NSLOT) begin
        n++;
        c = nxt[c];
      end
      return n;
    endfunction

    function void note_request(ipra_pkg::req_t r);
      ipra_pkg::rsp_t o;
      int prev, cur, steps;
      longint lim, cand, gap;
      bit done, found;
      o = '0;
      o.status = ipra_pkg::ST_REFUSED;
      prev = NULL_IDX;
      cur = used_head;
      steps = 0;
      case (r.cmd)
        ipra_pkg::CMD_CLAIM_FIXED: begin
          lim = longint'(r.port) + longint'(r.size);
          done = 0;
          if (lim <= 65536) begin
            while (cur < NSLOT && steps++ < NSLOT) begin
              if (rend[cur] <= r.port) begin
                prev = cur;
                cur = nxt[cur];
                continue;
              end
              if (rmark[cur] && rstart[cur] == r.port && longint'(rend[cur]) == lim) begin
                rmark[cur] = 0;
                o.status = ipra_pkg::ST_CLAIMED;
                o.granted_port = r.port;
                done = 1;
              end else if (longint'(rstart[cur]) < lim) begin
                done = 1;
              end
              break;
            end
            if (!done) begin
              o.status = add_after(prev, r.port, lim, 0) ?
                         ipra_pkg::ST_RECORDED : ipra_pkg::ST_FULL;
              o.granted_port = r.port;
            end
          end
        end
        ipra_pkg::CMD_CLAIM_ANY, ipra_pkg::CMD_RESERVE_ANY: begin
          cand = 'h400;
          found = 0;
          while (cur < NSLOT && steps++ < NSLOT) begin
            if (rstart[cur] >= 16'h400) begin
              gap = longint'(rstart[cur]) - cand;
              if (gap > longint'(r.size)) begin
                found = 1;
                break;
              end
              if (r.align > 0)
                cand = ((longint'(rend[cur]) + r.align - 1) / r.align) * r.align;
              else
                cand = rend[cur];
            end
            prev = cur;
            cur = nxt[cur];
          end
          if (found) begin
            o.granted_port = cand[15:0];
            o.status = add_after(prev, cand, cand + r.size,
                                 r.cmd == ipra_pkg::CMD_RESERVE_ANY)
                       ? ipra_pkg::ST_RECORDED : ipra_pkg::ST_FULL;
          end
        end
        ipra_pkg::CMD_FREE: begin
          o.status = ipra_pkg::ST_NOTFOUND;
          while (cur < NSLOT && steps++ < NSLOT) begin
            if (rstart[cur] == r.port) begin
              set_link(prev, nxt[cur]);
              nxt[cur] = free_head;
              free_head = cur;
              o.status = ipra_pkg::ST_FREED;
              break;
            end
            if (rstart[cur] > r.port) break;
            prev = cur;
            cur = nxt[cur];
          end
        end
        ipra_pkg::CMD_QUERY: begin
          o.status = ipra_pkg::ST_RECORDED;
          o.unused = 1;
          while (cur < NSLOT && steps++ < NSLOT) begin
            if ((r.port >= rstart[cur] && r.port < rend[cur]) ||
                (r.port <= rstart[cur] && r.end_port > rstart[cur])) begin
              o.unused = 0;
              break;
            end
            cur = nxt[cur];
          end
        end
        default: ;
      endcase
      pending_rsp.push_back(o);
    endfunction

    function void check_response(ipra_pkg::rsp_t got);
      ipra_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.granted_port !== want.granted_port) begin
        $error("granted_port: expected %h, got %h", want.granted_port, got.granted_port);
        errors++;
      end
      if (got.unused !== want.unused) begin
        $error("unused: expected %0d, got %0d", want.unused, got.unused);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  ipra_pkg::req_t in_data;
  ipra_pkg::rsp_t out_data;
  range_table_sb sb;
  int cycle_count;
  bit hold_req;

  io_port_range_allocator uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Checks each response transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_response(out_data);
  end

  // Receiver back-pressure: mostly random pattern, stretches of always-ready,
  // and one long hold-off of its own length once the sender asks for it.
  initial begin
    int mode;
    bit hold_done;
    out_ready = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_ready <= 0;
          repeat (300) @(negedge clk);
          hold_done = 1;
        end
        else if (mode == 0) out_ready <= 1;
        else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send_request(ipra_pkg::req_t r);
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_responses();
    in_valid <= 0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic ipra_pkg::req_t make_req(logic [2:0] c, logic [15:0] p,
                                              logic [16:0] s, logic [16:0] a,
                                              logic [16:0] e);
    ipra_pkg::req_t r;
    r.cmd = c;
    r.port = p;
    r.size = s;
    r.align = a;
    r.end_port = e;
    return r;
  endfunction

  // Random item biased toward small ranges so the table stays busy.
  function automatic ipra_pkg::req_t random_req();
    ipra_pkg::req_t r;
    int pick;
    r = ipra_pkg::req_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 30) r.cmd = ipra_pkg::CMD_CLAIM_FIXED;
    else if (pick < 45) r.cmd = ipra_pkg::CMD_CLAIM_ANY;
    else if (pick < 55) r.cmd = ipra_pkg::CMD_RESERVE_ANY;
    else if (pick < 80) r.cmd = ipra_pkg::CMD_FREE;
    else if (pick < 97) r.cmd = ipra_pkg::CMD_QUERY;
    else r.cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) != 0) begin
      r.size = 17'($urandom_range(0, 64));
      r.align = ($urandom_range(0, 2) == 0) ? 17'd0 : 17'(1 << $urandom_range(0, 8));
      r.port = 16'($urandom_range(0, 40) * 64 + $urandom_range(0, 3) * 16);
      r.end_port = 17'(r.port) + 17'($urandom_range(0, 200));
    end
    // Free and claim-fixed often target an existing range start.
    if ((r.cmd == ipra_pkg::CMD_FREE || r.cmd == ipra_pkg::CMD_CLAIM_FIXED) &&
        sb.used_head < NSLOT && $urandom_range(0, 1) == 1) begin
      int c;
      c = sb.used_head;
      repeat ($urandom_range(0, 8)) if (sb.nxt[c] < NSLOT) c = sb.nxt[c];
      r.port = sb.rstart[c];
      if (r.cmd == ipra_pkg::CMD_CLAIM_FIXED) r.size = 17'(sb.rend[c] - sb.rstart[c]);
    end
    return r;
  endfunction

  initial begin
    int sent;
    ipra_pkg::req_t r;
    bit held, drained;
    in_valid = 0;
    in_data = '0;
    hold_req = 0;
    held = 0;
    drained = 0;
    rst_n = 0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, each command, reservation takeover, full table.
    send_request(make_req(ipra_pkg::CMD_QUERY, 16'h0, 17'h0, 17'h0, 17'h10000));
    send_request(make_req(ipra_pkg::CMD_FREE, 16'hffff, 17'h0, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'hffff, 17'h1, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'hffff, 17'h2, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'h0, 17'h10000, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'h0, 17'h100, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'h80, 17'h10, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_RESERVE_ANY, 16'h0, 17'h20, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'h400, 17'h20, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_RESERVE_ANY, 16'h0, 17'h13, 17'h100, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_ANY, 16'h0, 17'h1ffff, 17'h1ffff, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_ANY, 16'h0, 17'h5, 17'h10000, 17'h0));
    send_request(make_req(ipra_pkg::CMD_QUERY, 16'h0, 17'h0, 17'h0, 17'h1));
    send_request(make_req(ipra_pkg::CMD_QUERY, 16'h90, 17'h0, 17'h0, 17'h91));
    send_request(make_req(ipra_pkg::CMD_QUERY, 16'hf000, 17'h0, 17'h0, 17'h1ffff));
    send_request(make_req(3'd7, 16'hffff, 17'h1ffff, 17'h1ffff, 17'h1ffff));
    send_request(make_req(ipra_pkg::CMD_FREE, 16'h400, 17'h0, 17'h0, 17'h0));
    for (int k = 0; k < 34; k++)
      send_request(make_req(ipra_pkg::CMD_CLAIM_FIXED, 16'(16'h1000 + k * 16'h100),
                            17'h8, 17'h0, 17'h0));
    send_request(make_req(ipra_pkg::CMD_CLAIM_ANY, 16'h0, 17'h4, 17'h0, 17'h0));
    drain_responses();
    for (int k = 0; k < 34; k++)
      send_request(make_req(ipra_pkg::CMD_FREE, 16'(16'h1000 + k * 16'h100),
                            17'h0, 17'h0, 17'h0));

    // Random bursts with gaps; one long receiver hold-off and one full drain.
    sent = 0;
    while (sent < 2000) begin
      if (!held && sent >= 600) begin
        // The receiver holds off on its own count while these keep coming.
        held = 1;
        hold_req = 1;
        repeat (8) begin
          send_request(random_req());
          sent++;
        end
      end
      if (!drained && sent >= 1200) begin
        drained = 1;
        drain_responses();
      end
      repeat ($urandom_range(1, 30)) begin
        r = random_req();
        send_request(r);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
    end
    drain_responses();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
